// ===== sv/mexp_pkg.sv =====
// Package for the expression tokenizer: word types, token kinds, lexer modes,
// character codes and result queue sizing.
// No dependencies.
package mexp_pkg;

   localparam int RspDepth  = 8;
   localparam int MaxBurst  = 3;
   localparam int RspPtrW   = $clog2(RspDepth);
   localparam int RspCntW   = $clog2(RspDepth + 1);
   localparam int RoomLimit = RspDepth - MaxBurst;

   typedef enum logic [4:0] {
      KIND_TEXT        = 5'd0,
      KIND_PLUS        = 5'd1,
      KIND_MINUS       = 5'd2,
      KIND_MUL         = 5'd3,
      KIND_DIV         = 5'd4,
      KIND_OR          = 5'd5,
      KIND_AND         = 5'd6,
      KIND_POW         = 5'd7,
      KIND_COMMA       = 5'd8,
      KIND_LPAREN      = 5'd9,
      KIND_RPAREN      = 5'd10,
      KIND_TRANSPOSE   = 5'd11,
      KIND_ARR_MUL     = 5'd12,
      KIND_ARR_DIV     = 5'd13,
      KIND_ARR_POW     = 5'd14,
      KIND_ARR_TRANS   = 5'd15,
      KIND_IDENT       = 5'd16,
      KIND_CONST       = 5'd17,
      KIND_END         = 5'd18,
      KIND_ERROR       = 5'd19
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE       = 3'd0,
      MODE_IDENT      = 3'd1,
      MODE_INT        = 3'd2,
      MODE_DOT        = 3'd3,
      MODE_FRAC       = 3'd4,
      MODE_EXP_LETTER = 3'd5,
      MODE_EXP_SIGN   = 3'd6,
      MODE_EXP_DIGITS = 3'd7
   } mode_type;

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_BAR     = 8'h7C;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_CARET   = 8'h5E;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_QUOTE   = 8'h27;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_LOWER_E = 8'h65;
   localparam logic [7:0] CH_UPPER_E = 8'h45;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_end;
   } req_word_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] text_byte;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] text_byte;
   } slot_type;

   typedef struct packed {
      slot_type [MaxBurst-1:0] slot;
   } batch_type;

endpackage

// ===== sv/mexp_lexer.sv =====
// Input register, lexer mode register and byte decode for the tokenizer.
// Produces up to three result slots per item. Depends on mexp_pkg.
module mexp_lexer import mexp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_word_type req_word,
   output logic         req_stall,
   input  logic         room,
   output logic         batch_push,
   output batch_type    batch
);

   logic         in_valid_ff, in_valid_in;
   req_word_type word_ff;
   mode_type     mode_ff, mode_in;
   logic         accept, move;

   logic [7:0]   c;
   logic         fin;
   slot_type     idle_slot, frac_s1, frac_s2, s0, s1, s2;
   mode_type     idle_mode, frac_mode;
   kind_type     op;

   function automatic logic is_digit(logic [7:0] v);
      return v >= "0" && v <= "9";
   endfunction

   function automatic logic is_alpha(logic [7:0] v);
      return (v >= "a" && v <= "z") || (v >= "A" && v <= "Z");
   endfunction

   function automatic logic is_space(logic [7:0] v);
      return v == CH_SPACE || (v >= CH_TAB && v <= CH_CR);
   endfunction

   function automatic slot_type text_slot(logic [7:0] v);
      slot_type r;
      r.valid     = 1'b1;
      r.kind      = KIND_TEXT;
      r.text_byte = v;
      return r;
   endfunction

   function automatic slot_type kind_slot(kind_type k);
      slot_type r;
      r.valid     = 1'b1;
      r.kind      = k;
      r.text_byte = 8'd0;
      return r;
   endfunction

   assign move        = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept ? 1'b1 : (move ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
      end else begin
         in_valid_ff <= in_valid_in;
         if (move) begin
            mode_ff <= mode_in;
         end
      end
      if (accept) begin
         word_ff <= req_word;
      end
   end

   assign c   = word_ff.char_code;
   assign fin = word_ff.is_end;

   always_comb begin
      case (c)
         CH_PLUS:   op = KIND_PLUS;
         CH_MINUS:  op = KIND_MINUS;
         CH_STAR:   op = KIND_MUL;
         CH_SLASH:  op = KIND_DIV;
         CH_BAR:    op = KIND_OR;
         CH_AMP:    op = KIND_AND;
         CH_CARET:  op = KIND_POW;
         CH_COMMA:  op = KIND_COMMA;
         CH_LPAREN: op = KIND_LPAREN;
         CH_RPAREN: op = KIND_RPAREN;
         CH_QUOTE:  op = KIND_TRANSPOSE;
         default:   op = KIND_TEXT;
      endcase
   end

   // decode of a byte that starts a new token
   always_comb begin
      idle_slot = '0;
      idle_mode = MODE_IDLE;
      if (is_space(c)) begin
         idle_slot = '0;
      end else if (op != KIND_TEXT) begin
         idle_slot = kind_slot(op);
      end else if (c == CH_DOT) begin
         idle_mode = MODE_DOT;
      end else if (is_alpha(c)) begin
         idle_slot = text_slot(c);
         idle_mode = MODE_IDENT;
      end else if (is_digit(c)) begin
         idle_slot = text_slot(c);
         idle_mode = MODE_INT;
      end else begin
         idle_slot = kind_slot(KIND_ERROR);
      end
   end

   // decode of a byte inside the fraction
   always_comb begin
      frac_s1   = '0;
      frac_s2   = '0;
      frac_mode = MODE_FRAC;
      if (is_digit(c)) begin
         frac_s1 = text_slot(c);
      end else if (c == CH_LOWER_E || c == CH_UPPER_E) begin
         frac_s1   = text_slot(c);
         frac_mode = MODE_EXP_LETTER;
      end else begin
         frac_s1   = kind_slot(KIND_CONST);
         frac_s2   = idle_slot;
         frac_mode = idle_mode;
      end
   end

   always_comb begin
      s0      = '0;
      s1      = '0;
      s2      = '0;
      mode_in = mode_ff;
      case (mode_ff)
         MODE_IDLE: begin
            if (fin) begin
               s2 = kind_slot(KIND_END);
            end else begin
               s2      = idle_slot;
               mode_in = idle_mode;
            end
         end
         MODE_IDENT: begin
            if (fin) begin
               s1      = kind_slot(KIND_IDENT);
               s2      = kind_slot(KIND_END);
               mode_in = MODE_IDLE;
            end else if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
               s1 = text_slot(c);
            end else begin
               s1      = kind_slot(KIND_IDENT);
               s2      = idle_slot;
               mode_in = idle_mode;
            end
         end
         MODE_INT: begin
            if (fin) begin
               s1      = kind_slot(KIND_CONST);
               s2      = kind_slot(KIND_END);
               mode_in = MODE_IDLE;
            end else if (is_digit(c)) begin
               s1 = text_slot(c);
            end else if (c == CH_DOT) begin
               s1      = text_slot(c);
               mode_in = MODE_FRAC;
            end else if (c == CH_LOWER_E || c == CH_UPPER_E) begin
               s1      = text_slot(c);
               mode_in = MODE_EXP_LETTER;
            end else begin
               s1      = kind_slot(KIND_CONST);
               s2      = idle_slot;
               mode_in = idle_mode;
            end
         end
         MODE_DOT: begin
            mode_in = MODE_IDLE;
            if (fin) begin
               s2 = kind_slot(KIND_END);
            end else if (c == CH_STAR) begin
               s1 = kind_slot(KIND_ARR_MUL);
            end else if (c == CH_SLASH) begin
               s1 = kind_slot(KIND_ARR_DIV);
            end else if (c == CH_CARET) begin
               s1 = kind_slot(KIND_ARR_POW);
            end else if (c == CH_QUOTE) begin
               s1 = kind_slot(KIND_ARR_TRANS);
            end else begin
               s0      = text_slot(CH_DOT);
               s1      = frac_s1;
               s2      = frac_s2;
               mode_in = frac_mode;
            end
         end
         MODE_FRAC: begin
            if (fin) begin
               s1      = kind_slot(KIND_CONST);
               s2      = kind_slot(KIND_END);
               mode_in = MODE_IDLE;
            end else begin
               s1      = frac_s1;
               s2      = frac_s2;
               mode_in = frac_mode;
            end
         end
         MODE_EXP_LETTER: begin
            if (fin) begin
               s1      = kind_slot(KIND_ERROR);
               mode_in = MODE_IDLE;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
               s1      = text_slot(c);
               mode_in = MODE_EXP_SIGN;
            end else if (is_digit(c)) begin
               s1      = text_slot(c);
               mode_in = MODE_EXP_DIGITS;
            end else begin
               s1      = kind_slot(KIND_ERROR);
               mode_in = MODE_IDLE;
            end
         end
         MODE_EXP_SIGN, MODE_EXP_DIGITS: begin
            if (fin) begin
               s1      = kind_slot(KIND_CONST);
               s2      = kind_slot(KIND_END);
               mode_in = MODE_IDLE;
            end else if (is_digit(c)) begin
               s1      = text_slot(c);
               mode_in = MODE_EXP_DIGITS;
            end else begin
               s1      = kind_slot(KIND_CONST);
               s2      = idle_slot;
               mode_in = idle_mode;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase
   end

   assign batch_push = move;
   assign batch.slot = {s2, s1, s0};

endmodule

// ===== sv/mexp_rsp_fifo.sv =====
// Result queue for the tokenizer: takes up to three slots per cycle, packs
// them in order, marks the last one and hands out one word per cycle while
// rsp is not stalled. Depends on mexp_pkg.
module mexp_rsp_fifo import mexp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         batch_push,
   input  batch_type    batch,
   output logic         room,
   output logic         rsp_valid,
   output rsp_word_type rsp_word,
   input  logic         rsp_stall
);

   rsp_word_type               mem_ff [RspDepth];
   logic         [RspPtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic         [RspCntW-1:0] count_ff, count_in, n_wr;
   logic         [RspPtrW-1:0] pos [MaxBurst];
   rsp_word_type               w [MaxBurst];
   logic                       v0, v1, v2, pop;

   assign v0 = batch.slot[0].valid;
   assign v1 = batch.slot[1].valid;
   assign v2 = batch.slot[2].valid;

   assign pos[0] = wr_ptr_ff;
   assign pos[1] = wr_ptr_ff + RspPtrW'(v0);
   assign pos[2] = wr_ptr_ff + RspPtrW'(v0) + RspPtrW'(v1);

   always_comb begin
      w[0] = '{kind: batch.slot[0].kind, text_byte: batch.slot[0].text_byte,
               last: !v1 && !v2};
      w[1] = '{kind: batch.slot[1].kind, text_byte: batch.slot[1].text_byte,
               last: !v2};
      w[2] = '{kind: batch.slot[2].kind, text_byte: batch.slot[2].text_byte,
               last: 1'b1};
   end

   assign n_wr      = batch_push ? RspCntW'(v0) + RspCntW'(v1) + RspCntW'(v2)
                                 : '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign count_in  = count_ff + n_wr - RspCntW'(pop);
   assign wr_ptr_in = wr_ptr_ff + RspPtrW'(n_wr);
   assign rd_ptr_in = rd_ptr_ff + RspPtrW'(pop);

   assign room      = count_ff <= RspCntW'(RoomLimit);
   assign rsp_valid = count_ff != '0;
   assign rsp_word  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (batch_push && v0) begin
         mem_ff[pos[0]] <= w[0];
      end
      if (batch_push && v1) begin
         mem_ff[pos[1]] <= w[1];
      end
      if (batch_push && v2) begin
         mem_ff[pos[2]] <= w[2];
      end
   end

endmodule

// ===== sv/math_expression_tokenizer.sv =====
// Top level of the expression tokenizer: lexer stage feeding the result queue.
// Depends on mexp_pkg, mexp_lexer and mexp_rsp_fifo.
//
// Takes one byte (or end marker) per req word and returns operator, text,
// identifier, constant, end and error words on rsp, last set on the final
// word of each byte. Each byte is decoded combinationally from its input
// register, so a byte can enter every cycle while the queue has room; it
// yields zero to three rsp words, and the rsp port drains one word per cycle
// while not stalled, so the sustained rate is one byte per cycle, or one per
// result word where bytes give more than one. Results pass through the input
// register and the result queue. The eight-word queue lets the decode run
// ahead while rsp stalls; req stalls once fewer than three slots are free.
module math_expression_tokenizer import mexp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_word_type req_word,
   output logic         req_stall,
   output logic         rsp_valid,
   output rsp_word_type rsp_word,
   input  logic         rsp_stall
);

   logic      room;
   logic      batch_push;
   batch_type batch;

   mexp_lexer u_lexer (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_word   (req_word),
      .req_stall  (req_stall),
      .room       (room),
      .batch_push (batch_push),
      .batch      (batch)
   );

   mexp_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .batch_push (batch_push),
      .batch      (batch),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word),
      .rsp_stall  (rsp_stall)
   );

endmodule

// ===== sv/mexp_checker.sv =====
// Port-level checks for the expression tokenizer, bound to its top level.
// Depends on mexp_pkg and math_expression_tokenizer.
module mexp_checker import mexp_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input req_word_type req_word,
   input logic         req_stall,
   input logic         rsp_valid,
   input rsp_word_type rsp_word,
   input logic         rsp_stall
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("results or stall present after reset");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.kind == KIND_END || rsp_word.kind == KIND_ERROR)
      |-> rsp_word.last)
      else $error("end or error word not marked last");

   a_text_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.kind != KIND_TEXT |-> rsp_word.text_byte == 8'd0)
      else $error("nonzero text byte on a non-text word");

endmodule

bind math_expression_tokenizer mexp_checker u_mexp_checker (.*);

// ===== tb/math_expression_tokenizer_tb.sv =====
// Testbench for math_expression_tokenizer: a queue-fed driver, a result monitor and a
// built-in lexer predictor checking every rsp word field by field.
// Depends on mexp_pkg and the math_expression_tokenizer RTL.
module math_expression_tokenizer_tb;
   import mexp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 60000;
   localparam int FeedTarget = 230;

   typedef struct {
      req_word_type word;
      bit           drain_first;
   } feed_item_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   req_word_type req_word = '0;
   logic         req_stall;
   logic         rsp_valid;
   rsp_word_type rsp_word;
   logic         rsp_stall = 1'b0;

   feed_item_type feed_q[$];
   rsp_word_type  token_due_q[$];
   rsp_word_type  burst_q[$];
   mode_type      lex_mode = MODE_IDLE;
   bit            drain_next = 1'b0;
   int            words_sent = 0;
   int            errors = 0;
   int            cycle_count = 0;
   logic          quiet;

   assign quiet = (words_sent >= 90) && (words_sent < 150);

   math_expression_tokenizer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_word  (req_word),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_stall (rsp_stall)
   );

   always #4 clock = ~clock;

   function bit is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function bit is_alpha(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function bit is_space(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function bit is_exp_letter(logic [7:0] c);
      return (c == CH_LOWER_E) || (c == CH_UPPER_E);
   endfunction

   function kind_type op_kind(logic [7:0] c);
      case (c)
         CH_PLUS:   return KIND_PLUS;
         CH_MINUS:  return KIND_MINUS;
         CH_STAR:   return KIND_MUL;
         CH_SLASH:  return KIND_DIV;
         CH_BAR:    return KIND_OR;
         CH_AMP:    return KIND_AND;
         CH_CARET:  return KIND_POW;
         CH_COMMA:  return KIND_COMMA;
         CH_LPAREN: return KIND_LPAREN;
         CH_RPAREN: return KIND_RPAREN;
         CH_QUOTE:  return KIND_TRANSPOSE;
         default:   return KIND_TEXT;
      endcase
   endfunction

   function void emit(kind_type k, logic [7:0] ch);
      rsp_word_type w;
      w.kind = k;
      w.text_byte = (k == KIND_TEXT) ? ch : 8'h00;
      w.last = 1'b0;
      burst_q.push_back(w);
   endfunction

   function void idle_byte(logic [7:0] c);
      lex_mode = MODE_IDLE;
      if (!is_space(c)) begin
         if (op_kind(c) != KIND_TEXT) begin
            emit(op_kind(c), 8'h00);
         end else if (c == CH_DOT) begin
            lex_mode = MODE_DOT;
         end else if (is_alpha(c)) begin
            emit(KIND_TEXT, c);
            lex_mode = MODE_IDENT;
         end else if (is_digit(c)) begin
            emit(KIND_TEXT, c);
            lex_mode = MODE_INT;
         end else begin
            emit(KIND_ERROR, 8'h00);
         end
      end
   endfunction

   function void close_token(kind_type k, logic [7:0] c);
      emit(k, 8'h00);
      idle_byte(c);
   endfunction

   function void close_at_end(kind_type k);
      emit(k, 8'h00);
      emit(KIND_END, 8'h00);
      lex_mode = MODE_IDLE;
   endfunction

   function void frac_byte(logic [7:0] c);
      if (is_digit(c)) begin
         emit(KIND_TEXT, c);
         lex_mode = MODE_FRAC;
      end else if (is_exp_letter(c)) begin
         emit(KIND_TEXT, c);
         lex_mode = MODE_EXP_LETTER;
      end else begin
         close_token(KIND_CONST, c);
      end
   endfunction

   function void lex_byte(req_word_type w);
      logic [7:0]   c;
      rsp_word_type r;
      int           i;
      c = w.char_code;
      burst_q.delete();
      case (lex_mode)
         MODE_IDLE: begin
            if (w.is_end) emit(KIND_END, 8'h00);
            else idle_byte(c);
         end
         MODE_IDENT: begin
            if (w.is_end) close_at_end(KIND_IDENT);
            else if (is_alpha(c) || is_digit(c) || c == CH_UNDER) emit(KIND_TEXT, c);
            else close_token(KIND_IDENT, c);
         end
         MODE_INT: begin
            if (w.is_end) begin
               close_at_end(KIND_CONST);
            end else if (is_digit(c)) begin
               emit(KIND_TEXT, c);
            end else if (c == CH_DOT) begin
               emit(KIND_TEXT, c);
               lex_mode = MODE_FRAC;
            end else if (is_exp_letter(c)) begin
               emit(KIND_TEXT, c);
               lex_mode = MODE_EXP_LETTER;
            end else begin
               close_token(KIND_CONST, c);
            end
         end
         MODE_DOT: begin
            lex_mode = MODE_IDLE;
            if (w.is_end) begin
               emit(KIND_END, 8'h00);
            end else if (c == CH_STAR) begin
               emit(KIND_ARR_MUL, 8'h00);
            end else if (c == CH_SLASH) begin
               emit(KIND_ARR_DIV, 8'h00);
            end else if (c == CH_CARET) begin
               emit(KIND_ARR_POW, 8'h00);
            end else if (c == CH_QUOTE) begin
               emit(KIND_ARR_TRANS, 8'h00);
            end else begin
               emit(KIND_TEXT, CH_DOT);
               frac_byte(c);
            end
         end
         MODE_FRAC: begin
            if (w.is_end) close_at_end(KIND_CONST);
            else frac_byte(c);
         end
         MODE_EXP_LETTER: begin
            if (!w.is_end && (c == CH_PLUS || c == CH_MINUS)) begin
               emit(KIND_TEXT, c);
               lex_mode = MODE_EXP_SIGN;
            end else if (!w.is_end && is_digit(c)) begin
               emit(KIND_TEXT, c);
               lex_mode = MODE_EXP_DIGITS;
            end else begin
               emit(KIND_ERROR, 8'h00);
               lex_mode = MODE_IDLE;
            end
         end
         default: begin
            if (w.is_end) begin
               close_at_end(KIND_CONST);
            end else if (is_digit(c)) begin
               emit(KIND_TEXT, c);
               lex_mode = MODE_EXP_DIGITS;
            end else begin
               close_token(KIND_CONST, c);
            end
         end
      endcase
      for (i = 0; i < burst_q.size(); i++) begin
         r = burst_q[i];
         r.last = (i == burst_q.size() - 1);
         token_due_q.push_back(r);
      end
   endfunction

   function void add_item(logic [7:0] c, logic e);
      feed_item_type it;
      it.word.char_code = c;
      it.word.is_end = e;
      it.drain_first = drain_next;
      drain_next = 1'b0;
      feed_q.push_back(it);
   endfunction

   function void add_char(logic [7:0] c);
      add_item(c, 1'b0);
   endfunction

   function void add_end();
      add_item(8'($urandom_range(0, 255)), 1'b1);
   endfunction

   function logic [7:0] rand_digit();
      return "0" + 8'($urandom_range(0, 9));
   endfunction

   function logic [7:0] rand_letter();
      return ($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25));
   endfunction

   function logic [7:0] rand_op();
      case ($urandom_range(0, 10))
         0:       return CH_PLUS;
         1:       return CH_MINUS;
         2:       return CH_STAR;
         3:       return CH_SLASH;
         4:       return CH_BAR;
         5:       return CH_AMP;
         6:       return CH_CARET;
         7:       return CH_COMMA;
         8:       return CH_LPAREN;
         9:       return CH_RPAREN;
         default: return CH_QUOTE;
      endcase
   endfunction

   function logic [7:0] rand_space();
      return $urandom_range(0, 5) == 0 ? CH_SPACE : 8'($urandom_range(9, 13));
   endfunction

   function void add_number();
      int k;
      if ($urandom_range(0, 9) == 0) begin
         add_char(CH_DOT);
         repeat ($urandom_range(1, 2)) add_char(rand_digit());
      end else begin
         repeat ($urandom_range(1, 3)) add_char(rand_digit());
         if ($urandom_range(0, 1)) begin
            add_char(CH_DOT);
            repeat ($urandom_range(0, 2)) add_char(rand_digit());
         end
      end
      if ($urandom_range(0, 9) < 3) begin
         add_char($urandom_range(0, 1) ? CH_LOWER_E : CH_UPPER_E);
         k = $urandom_range(0, 9);
         if (k >= 2) begin
            if (k < 4 || $urandom_range(0, 1)) add_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            if (k >= 4) repeat ($urandom_range(1, 2)) add_char(rand_digit());
         end
      end
   endfunction

   function void add_token();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         add_char(rand_letter());
         repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 2))
               0:       add_char(rand_letter());
               1:       add_char(rand_digit());
               default: add_char(CH_UNDER);
            endcase
         end
      end else if (r < 50) begin
         add_number();
      end else if (r < 75) begin
         add_char(rand_op());
      end else if (r < 85) begin
         add_char(CH_DOT);
         case ($urandom_range(0, 3))
            0:       add_char(CH_STAR);
            1:       add_char(CH_SLASH);
            2:       add_char(CH_CARET);
            default: add_char(CH_QUOTE);
         endcase
      end else if (r < 93) begin
         add_char(rand_space());
      end else begin
         add_char(8'($urandom_range(0, 255)));
      end
   endfunction

   function void add_expression(bit drain);
      drain_next = drain;
      repeat ($urandom_range(1, 6)) begin
         add_token();
         if ($urandom_range(0, 9) < 3) add_char(rand_space());
      end
      add_end();
   endfunction

   function void add_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) add_char(s[i]);
   endfunction

   // driver: hold the word until accepted, predict on acceptance
   always @(posedge clock) begin
      logic gap;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         gap = !quiet && ($urandom_range(0, 99) < 22);
         if (req_valid && !req_stall) begin
            lex_byte(req_word);
            words_sent <= words_sent + 1;
         end
         if (!req_valid || !req_stall) begin
            if (feed_q.size() != 0 && !gap &&
                !(feed_q[0].drain_first && token_due_q.size() != 0)) begin
               req_valid <= 1'b1;
               req_word <= feed_q.pop_front().word;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each accepted word with the oldest expectation
   always @(posedge clock) begin
      rsp_word_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (token_due_q.size() == 0) begin
               $error("unexpected word: kind %0d text_byte %0h last %0b",
                      rsp_word.kind, rsp_word.text_byte, rsp_word.last);
               errors++;
            end else begin
               due = token_due_q.pop_front();
               if (rsp_word.kind !== due.kind) begin
                  $error("kind: expected %0d, actual %0d", due.kind, rsp_word.kind);
                  errors++;
               end
               if (rsp_word.text_byte !== due.text_byte) begin
                  $error("text_byte: expected %0h, actual %0h", due.text_byte,
                         rsp_word.text_byte);
                  errors++;
               end
               if (rsp_word.last !== due.last) begin
                  $error("last: expected %0b, actual %0b", due.last, rsp_word.last);
                  errors++;
               end
            end
         end
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 22);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("math_expression_tokenizer: mismatch");
         $finish;
      end
   end

   initial begin
      int n;
      add_char(8'h00);
      add_char(8'hFF);
      add_text("x_1.'2.5e-7");
      add_char(CH_TAB);
      add_text("1e+,.x 3E");
      add_end();
      add_char(CH_DOT);
      add_end();
      n = 0;
      while (feed_q.size() < FeedTarget) begin
         add_expression(n % 12 == 0);
         n++;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (feed_q.size() != 0 || req_valid || token_due_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      if (errors == 0 && token_due_q.size() == 0) begin
         $display("math_expression_tokenizer: match");
      end else begin
         $display("math_expression_tokenizer: mismatch");
      end
      $finish;
   end

endmodule

// ===== math_expression_tokenizer.f =====
sv/mexp_pkg.sv
sv/mexp_lexer.sv
sv/mexp_rsp_fifo.sv
sv/math_expression_tokenizer.sv
sv/mexp_checker.sv
tb/math_expression_tokenizer_tb.sv
